### src/bsm_pkg.sv
// ---------------------------------------------------------------------------
// bsm_pkg
// Shared constants and control types for the radix-2 Booth multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

    localparam int WIDTH  = 16;
    localparam int PROD_W = 2 * WIDTH;
    localparam int CNT_W  = $clog2(WIDTH + 1);

    localparam logic [CNT_W-1:0] STEPS = CNT_W'(WIDTH);

    // Booth pair {multiplier bit 0, extra low bit}
    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture operands, clear accumulator and extra bit
        logic step;      // run one add/subtract and shift
        logic load_out;  // capture the post-step product into the output register
    } bsm_cmd_t;

endpackage : bsm_pkg

`default_nettype wire

### src/bsm_datapath.sv
// ---------------------------------------------------------------------------
// bsm_datapath
// Accumulator, multiplier shift register, extra bit and product register.
// ---------------------------------------------------------------------------
`default_nettype none

module bsm_datapath (
    input  wire logic                          clk,
    input  wire bsm_pkg::bsm_cmd_t             cmd,
    input  wire logic signed [bsm_pkg::WIDTH-1:0]  multiplicand,
    input  wire logic signed [bsm_pkg::WIDTH-1:0]  multiplier,
    output logic signed [bsm_pkg::PROD_W-1:0]      product
);

    logic [bsm_pkg::WIDTH-1:0]  acc_reg;
    logic [bsm_pkg::WIDTH-1:0]  acc_next;
    logic [bsm_pkg::WIDTH-1:0]  mul_reg;
    logic [bsm_pkg::WIDTH-1:0]  mul_next;
    logic [bsm_pkg::WIDTH-1:0]  mcand_reg;
    logic                       extra_reg;
    logic [bsm_pkg::WIDTH-1:0]  sum;
    logic [bsm_pkg::PROD_W-1:0] product_reg;

    always_comb
    begin
        case ({mul_reg[0], extra_reg})
            bsm_pkg::BOOTH_SUB: sum = acc_reg - mcand_reg;
            bsm_pkg::BOOTH_ADD: sum = acc_reg + mcand_reg;
            default:            sum = acc_reg;
        endcase
        // arithmetic shift of the acc:mul:extra chain
        acc_next = {sum[bsm_pkg::WIDTH-1], sum[bsm_pkg::WIDTH-1:1]};
        mul_next = {sum[0], mul_reg[bsm_pkg::WIDTH-1:1]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mcand_reg <= multiplicand;
            mul_reg   <= multiplier;
            acc_reg   <= '0;
            extra_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            acc_reg   <= acc_next;
            mul_reg   <= mul_next;
            extra_reg <= mul_reg[0];
        end
        if (cmd.load_out)
        begin
            product_reg <= {acc_next, mul_next};
        end
    end

    assign product = product_reg;

endmodule : bsm_datapath

`default_nettype wire

### src/bsm_ctrl.sv
// ---------------------------------------------------------------------------
// bsm_ctrl
// Iteration counter, handshake control and output valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module bsm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output bsm_pkg::bsm_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    logic [bsm_pkg::CNT_W-1:0] cnt_reg;
    logic [bsm_pkg::CNT_W-1:0] cnt_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_busy;
    logic                      last;
    logic                      in_xfer;

    assign out_busy = out_valid_reg && !out_ready;
    assign last     = (cnt_reg == bsm_pkg::CNT_W'(1));
    // take a new pair when idle, or in the final step while the output slot is free
    assign in_ready = (state_reg == ST_IDLE) ||
                      ((state_reg == ST_RUN) && last && !out_busy);
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        cmd.load     = in_xfer;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_RUN:
            begin
                // hold the final step until the output slot frees up
                if (!(last && out_busy))
                begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg - bsm_pkg::CNT_W'(1);
                end
                if (last && !out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (in_xfer)
        begin
            state_next = ST_RUN;
            cnt_next   = bsm_pkg::STEPS;
        end
        out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule : bsm_ctrl

`default_nettype wire

### src/booth_signed_multiplier_unit.sv
// ---------------------------------------------------------------------------
// booth_signed_multiplier_unit
// Iteration: after an input transfer, one Booth add/subtract and shift per
//   cycle in the accumulator datapath; the final step waits while the
//   output register holds an unaccepted product. A new operand pair is
//   taken in the cycle of the final step while the output register is free.
// Reset: rst_n asynchronous, active low; clears control state and out_valid.
// ---------------------------------------------------------------------------
`default_nettype none

module booth_signed_multiplier_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [bsm_pkg::WIDTH-1:0]    multiplicand,
    input  wire logic signed [bsm_pkg::WIDTH-1:0]    multiplier,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [bsm_pkg::PROD_W-1:0]        product
);

    bsm_pkg::bsm_cmd_t cmd;

    bsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    bsm_datapath u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .product      (product)
    );

endmodule : booth_signed_multiplier_unit

`default_nettype wire

### src/bsm_checker.sv
// ---------------------------------------------------------------------------
// bsm_checker
// Port-level checks on the Booth multiplier's handshake and timing.
// ---------------------------------------------------------------------------
`default_nettype none

module bsm_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [bsm_pkg::PROD_W-1:0]   product
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(product))
        else $error("stalled product changed or dropped");

    // busy right after an operand transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted again during iteration");

    // a result is pending by the time the iterations are done
    a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##(bsm_pkg::WIDTH + 1) out_valid)
        else $error("product missing after iterations");

    // a new result shows up only at the end of an iteration run
    a_rise_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready, 2))
        else $error("product appeared without a running item");

endmodule : bsm_checker

bind booth_signed_multiplier_unit bsm_checker u_bsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .product   (product)
);

`default_nettype wire

### test/tb_booth_signed_multiplier_unit.sv
// ---------------------------------------------------------------------------
// tb_booth_signed_multiplier_unit
// Checks the radix-2 Booth multiplier against an in-bench Booth predictor.
// Each transfer is predicted at the input handshake and compared with the
// next product at the output. Corners run first, then random operand pairs
// under three stall mixes, with a full drain between the mixes.
// ---------------------------------------------------------------------------
module tb_booth_signed_multiplier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH  = bsm_pkg::WIDTH;
    localparam int PROD_W = bsm_pkg::PROD_W;

    typedef struct packed {
        logic [WIDTH-1:0] mcand;
        logic [WIDTH-1:0] mplier;
    } operand_pair_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [WIDTH-1:0]  multiplicand = '0;
    logic signed [WIDTH-1:0]  multiplier = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [PROD_W-1:0] product;

    operand_pair_t     pending_pairs[$];
    logic [PROD_W-1:0] expected_products[$];
    operand_pair_t     next_pair;
    logic [PROD_W-1:0] want_product;

    int send_idle_pct = 36;
    int recv_idle_pct = 45;
    int pairs_sent = 0;
    int products_seen = 0;
    int mismatches = 0;

    booth_signed_multiplier_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .product      (product)
    );

    // Bit-serial Booth recoding with a WIDTH-bit accumulator that wraps.
    function automatic logic [PROD_W-1:0] booth_product(input logic [WIDTH-1:0] mcand,
                                                        input logic [WIDTH-1:0] mplier);
        logic [WIDTH-1:0] acc;
        logic [WIDTH-1:0] q;
        logic             q_extra;
        int               k;
        acc = '0;
        q = mplier;
        q_extra = 1'b0;
        for (k = 0; k < WIDTH; k++)
        begin
            case ({q[0], q_extra})
                bsm_pkg::BOOTH_SUB: acc = acc - mcand;
                bsm_pkg::BOOTH_ADD: acc = acc + mcand;
                default: ;
            endcase
            // arithmetic shift of the acc:q:extra chain
            {acc, q, q_extra} = {acc[WIDTH-1], acc, q};
        end
        return {acc, q};
    endfunction

    function automatic logic [WIDTH-1:0] corner_value();
        case ($urandom_range(5))
            0: return {1'b1, {(WIDTH-1){1'b0}}};
            1: return {1'b0, {(WIDTH-1){1'b1}}};
            2: return '1;
            3: return '0;
            4: return WIDTH'(1);
            default: return {1'b1, {(WIDTH-2){1'b0}}, 1'b1};
        endcase
    endfunction

    function automatic operand_pair_t random_pair();
        operand_pair_t pair;
        pair.mcand = WIDTH'($urandom);
        pair.mplier = WIDTH'($urandom);
        case ($urandom_range(9))
            0: pair.mcand = corner_value();
            1: pair.mplier = corner_value();
            2:
            begin
                pair.mcand = WIDTH'($signed($urandom_range(15)) - 8);
                pair.mplier = WIDTH'($signed($urandom_range(15)) - 8);
            end
            default: ;
        endcase
        return pair;
    endfunction

    task automatic queue_pair(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b);
        operand_pair_t pair;
        pair.mcand = a;
        pair.mplier = b;
        pending_pairs.push_back(pair);
    endtask

    task automatic queue_random(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            pending_pairs.push_back(random_pair());
        end
    endtask

    // Sample at the falling edge so every handshake of the cycle has settled.
    task automatic wait_drained();
        while (pending_pairs.size() != 0 || in_valid || expected_products.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Driver: predict at each input transfer, then present the next pair or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            multiplicand <= '0;
            multiplier <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_products.push_back(booth_product(multiplicand, multiplier));
                pairs_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_pair = pending_pairs.pop_front();
                    in_valid <= 1'b1;
                    multiplicand <= next_pair.mcand;
                    multiplier <= next_pair.mplier;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each output transfer with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                products_seen++;
                if (expected_products.size() == 0)
                begin
                    $display("%0t ns: product %h with no prediction pending", $time, product);
                    mismatches++;
                end
                else
                begin
                    want_product = expected_products.pop_front();
                    if (product !== want_product)
                    begin
                        $display("%0t ns: product mismatch, expected %h, actual %h",
                                 $time, want_product, product);
                        mismatches++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corners: zero, extremes, most negative multiplicand, bit patterns
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'h7FFF, 16'h7FFF);
        queue_pair(16'h8000, 16'h8000);
        queue_pair(16'h8000, 16'h7FFF);
        queue_pair(16'h7FFF, 16'h8000);
        queue_pair(16'h8000, 16'h0001);
        queue_pair(16'h8000, 16'hFFFF);
        queue_pair(16'h8000, 16'h0000);
        queue_pair(16'h0000, 16'h8000);
        queue_pair(16'h0001, 16'h8000);
        queue_pair(16'hFFFF, 16'hFFFF);
        queue_pair(16'h0001, 16'hFFFF);
        queue_pair(16'hFFFF, 16'h0001);
        queue_pair(16'h5555, 16'hAAAA);
        queue_pair(16'hAAAA, 16'h5555);
        queue_pair(16'hAAAA, 16'hAAAA);
        queue_pair(16'h5555, 16'h5555);
        queue_pair(16'h0001, 16'h8001);
        queue_pair(16'h8001, 16'h7FFF);
        queue_pair(16'h1234, 16'hFEDC);
        queue_random(500);
        wait_drained();

        send_idle_pct = 45;
        recv_idle_pct = 36;
        queue_random(500);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(500);
        wait_drained();

        // catch any stray product after the last one
        repeat (2 * WIDTH + 8) @(posedge clk);

        $display("Ran %0d operand pairs (corners, then random under three stall mixes);",
                 pairs_sent);
        $display("%0d products compared, %0d mismatches.", products_seen, mismatches);
        if (mismatches == 0 && expected_products.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
